// File: hw/rtl/gcm_pkg.sv
// shared constants and types for the gated color matrix
package gcm_pkg;

    // default fixed-point geometry
    localparam int FRACTION_BITS_DEF = 14;
    localparam int COEFF_WIDTH_DEF   = 16;

    // channel geometry
    localparam int CHAN_W   = 8;
    localparam int CHAN_MAX = 255;

    // pixel category codes
    localparam logic [1:0] CLASS_BYPASS         = 2'd0;
    localparam logic [1:0] CLASS_LAST_TRANSFORM = 2'd2;
    localparam logic [1:0] CLASS_INVALID        = 2'd3;

    // configuration register indexes
    localparam int          CFG_IDX_W        = 8;
    localparam logic [7:0]  REG_ENABLE       = 8'd0;
    localparam logic [7:0]  REG_ROW_RED      = 8'd1;
    localparam logic [7:0]  REG_ROW_GREEN    = 8'd2;
    localparam logic [7:0]  REG_ROW_BLUE     = 8'd3;

    // per-stage load enables handed to the row datapaths
    typedef struct packed {
        logic s1;   // product stage loads
        logic s2;   // sum stage loads
    } stage_adv_t;

endpackage

// File: hw/rtl/gcm_row_pipe.sv
// one matrix row: registered products, registered rounded sum, clamp to a byte
module gcm_row_pipe #(
    parameter int FRACTION_BITS = gcm_pkg::FRACTION_BITS_DEF,
    parameter int COEFF_WIDTH   = gcm_pkg::COEFF_WIDTH_DEF
) (
    input  logic                        aclk,
    input  gcm_pkg::stage_adv_t         adv,
    input  logic [3*COEFF_WIDTH-1:0]    coeff_row,
    input  logic [gcm_pkg::CHAN_W-1:0]  pix_red,
    input  logic [gcm_pkg::CHAN_W-1:0]  pix_green,
    input  logic [gcm_pkg::CHAN_W-1:0]  pix_blue,
    output logic [gcm_pkg::CHAN_W-1:0]  chan_out
);

    localparam int CW     = COEFF_WIDTH;
    localparam int PROD_W = COEFF_WIDTH + gcm_pkg::CHAN_W + 1;
    localparam int SUM_W  = PROD_W + 2;

    logic signed [PROD_W-1:0] coef_ext [3];
    logic signed [PROD_W-1:0] pix_ext  [3];
    logic signed [PROD_W-1:0] prod_next [3];
    logic signed [PROD_W-1:0] prod_reg  [3];
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  quot;
    logic signed [SUM_W-1:0]  round_half;

    // sign-extend coefficients, zero-extend channels
    always_comb begin
        pix_ext[0] = $signed({{(PROD_W-gcm_pkg::CHAN_W){1'b0}}, pix_red});
        pix_ext[1] = $signed({{(PROD_W-gcm_pkg::CHAN_W){1'b0}}, pix_green});
        pix_ext[2] = $signed({{(PROD_W-gcm_pkg::CHAN_W){1'b0}}, pix_blue});
        for (int k = 0; k < 3; k++) begin
            coef_ext[k]  = $signed({{(PROD_W-CW){coeff_row[k*CW+CW-1]}},
                                    coeff_row[k*CW +: CW]});
            prod_next[k] = coef_ext[k] * pix_ext[k];
        end
    end

    // stage 1: products
    always_ff @(posedge aclk) begin
        if (adv.s1) begin
            for (int k = 0; k < 3; k++) begin
                prod_reg[k] <= prod_next[k];
            end
        end
    end

    // rounded sum of the three products
    always_comb begin
        round_half = SUM_W'(1) <<< (FRACTION_BITS - 1);
        sum_next   = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1])
                   + SUM_W'(prod_reg[2]) + round_half;
    end

    // stage 2: sum
    always_ff @(posedge aclk) begin
        if (adv.s2) begin
            sum_reg <= sum_next;
        end
    end

    // floor shift and clamp to the byte range
    always_comb begin
        quot = sum_reg >>> FRACTION_BITS;
        if (sum_reg < 0) begin
            chan_out = '0;
        end else if (quot >= SUM_W'(gcm_pkg::CHAN_MAX)) begin
            chan_out = gcm_pkg::CHAN_W'(gcm_pkg::CHAN_MAX);
        end else begin
            chan_out = quot[gcm_pkg::CHAN_W-1:0];
        end
    end

endmodule

// File: hw/rtl/gated_color_matrix_q14_core.sv
// top level: gated 3x3 color matrix on an rgb pixel stream
// an input beat passes through the product, sum and output registers, in that order
// accepts one pixel per cycle while the output is not stalled
// ready on the input follows stage occupancy; a stall holds each full stage in place while empty stages still fill
// reset (aresetn low, synchronous): pipeline empties, enable clears, matrix is identity
// configuration port is always ready; writes are registered and take effect in the next cycle
module gated_color_matrix_q14_core #(
    parameter int FRACTION_BITS = gcm_pkg::FRACTION_BITS_DEF,
    parameter int COEFF_WIDTH   = gcm_pkg::COEFF_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gcm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [3*COEFF_WIDTH-1:0]      cfg_wdata,
    // pixel input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_pixel_class,
    input  logic [gcm_pkg::CHAN_W-1:0]    s_in_red,
    input  logic [gcm_pkg::CHAN_W-1:0]    s_in_green,
    input  logic [gcm_pkg::CHAN_W-1:0]    s_in_blue,
    input  logic                          s_frame_end,
    // pixel output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gcm_pkg::CHAN_W-1:0]    m_out_red,
    output logic [gcm_pkg::CHAN_W-1:0]    m_out_green,
    output logic [gcm_pkg::CHAN_W-1:0]    m_out_blue,
    output logic                          m_class_invalid,
    output logic                          m_frame_end_out
);

    localparam int ROW_W = 3 * COEFF_WIDTH;
    localparam int CHW   = gcm_pkg::CHAN_W;

    // identity rows; bits shifted past the row width drop out
    localparam logic [ROW_W-1:0] ROW_RED_RST   = ROW_W'(1) << FRACTION_BITS;
    localparam logic [ROW_W-1:0] ROW_GREEN_RST = ROW_W'(1) << (FRACTION_BITS + COEFF_WIDTH);
    localparam logic [ROW_W-1:0] ROW_BLUE_RST  =
        ROW_W'(1) << (FRACTION_BITS + 2 * COEFF_WIDTH);

    // configuration registers
    logic             enable_reg;
    logic [ROW_W-1:0] row_red_reg;
    logic [ROW_W-1:0] row_green_reg;
    logic [ROW_W-1:0] row_blue_reg;

    // stage valid bits and flow control
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic m_valid_reg, m_valid_next;
    logic en1, en2, out_en;
    gcm_pkg::stage_adv_t adv;

    // side data per stage
    logic [CHW-1:0] pix1_r_reg, pix1_g_reg, pix1_b_reg;
    logic           xform1_reg, inval1_reg, fe1_reg;
    logic [CHW-1:0] pix2_r_reg, pix2_g_reg, pix2_b_reg;
    logic           xform2_reg, inval2_reg, fe2_reg;
    logic           xform_next, inval_next;

    // output registers
    logic [CHW-1:0] out_r_reg, out_g_reg, out_b_reg;
    logic           out_inval_reg, out_fe_reg;

    logic [CHW-1:0] mat_r, mat_g, mat_b;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= 1'b0;
            row_red_reg   <= ROW_RED_RST;
            row_green_reg <= ROW_GREEN_RST;
            row_blue_reg  <= ROW_BLUE_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                gcm_pkg::REG_ENABLE:    enable_reg    <= cfg_wdata[0];
                gcm_pkg::REG_ROW_RED:   row_red_reg   <= cfg_wdata;
                gcm_pkg::REG_ROW_GREEN: row_green_reg <= cfg_wdata;
                gcm_pkg::REG_ROW_BLUE:  row_blue_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // stall chain from the output back to the input
    always_comb begin
        out_en       = !m_valid_reg || m_ready;
        en2          = !v2_reg || out_en;
        en1          = !v1_reg || en2;
        v1_next      = en1 ? s_valid : v1_reg;
        v2_next      = en2 ? v1_reg : v2_reg;
        m_valid_next = out_en ? v2_reg : m_valid_reg;
        adv.s1       = en1;
        adv.s2       = en2;
    end

    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // category decode, gated by enable
    always_comb begin
        xform_next = enable_reg && (s_pixel_class != gcm_pkg::CLASS_BYPASS)
                     && (s_pixel_class <= gcm_pkg::CLASS_LAST_TRANSFORM);
        inval_next = enable_reg && (s_pixel_class == gcm_pkg::CLASS_INVALID);
    end

    // stage 1 and stage 2 side data
    always_ff @(posedge aclk) begin
        if (en1) begin
            pix1_r_reg <= s_in_red;
            pix1_g_reg <= s_in_green;
            pix1_b_reg <= s_in_blue;
            xform1_reg <= xform_next;
            inval1_reg <= inval_next;
            fe1_reg    <= s_frame_end;
        end
        if (en2) begin
            pix2_r_reg <= pix1_r_reg;
            pix2_g_reg <= pix1_g_reg;
            pix2_b_reg <= pix1_b_reg;
            xform2_reg <= xform1_reg;
            inval2_reg <= inval1_reg;
            fe2_reg    <= fe1_reg;
        end
    end

    // matrix rows
    gcm_row_pipe #(
        .FRACTION_BITS (FRACTION_BITS),
        .COEFF_WIDTH   (COEFF_WIDTH)
    ) u_row_red (
        .aclk      (aclk),
        .adv       (adv),
        .coeff_row (row_red_reg),
        .pix_red   (s_in_red),
        .pix_green (s_in_green),
        .pix_blue  (s_in_blue),
        .chan_out  (mat_r)
    );

    gcm_row_pipe #(
        .FRACTION_BITS (FRACTION_BITS),
        .COEFF_WIDTH   (COEFF_WIDTH)
    ) u_row_green (
        .aclk      (aclk),
        .adv       (adv),
        .coeff_row (row_green_reg),
        .pix_red   (s_in_red),
        .pix_green (s_in_green),
        .pix_blue  (s_in_blue),
        .chan_out  (mat_g)
    );

    gcm_row_pipe #(
        .FRACTION_BITS (FRACTION_BITS),
        .COEFF_WIDTH   (COEFF_WIDTH)
    ) u_row_blue (
        .aclk      (aclk),
        .adv       (adv),
        .coeff_row (row_blue_reg),
        .pix_red   (s_in_red),
        .pix_green (s_in_green),
        .pix_blue  (s_in_blue),
        .chan_out  (mat_b)
    );

    // stage 3: pick matrix or pass-through into the output register
    always_ff @(posedge aclk) begin
        if (out_en) begin
            out_r_reg     <= xform2_reg ? mat_r : pix2_r_reg;
            out_g_reg     <= xform2_reg ? mat_g : pix2_g_reg;
            out_b_reg     <= xform2_reg ? mat_b : pix2_b_reg;
            out_inval_reg <= inval2_reg;
            out_fe_reg    <= fe2_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_red       = out_r_reg;
    assign m_out_green     = out_g_reg;
    assign m_out_blue      = out_b_reg;
    assign m_class_invalid = out_inval_reg;
    assign m_frame_end_out = out_fe_reg;

endmodule
